// ===== rtl/ps2tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2tb_pkg
// Shared types, codes and character tables for the scan-code decoder.
// ----------------------------------------------------------------------------
package ps2tb_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CODE_PREFIX      = 8'hE0;
    localparam logic [7:0] CODE_LSHIFT_DN   = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT_DN   = 8'h36;
    localparam logic [7:0] CODE_LSHIFT_UP   = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_UP   = 8'hB6;
    localparam logic [7:0] CODE_CAPS        = 8'h3A;
    localparam logic [6:0] BASE_CTRL        = 7'h1D;
    localparam logic [6:0] BASE_ALT         = 7'h38;
    localparam logic [7:0] ROM_SIZE         = 8'd58;

    localparam logic [6:0] BASE_UP     = 7'h48;
    localparam logic [6:0] BASE_DOWN   = 7'h50;
    localparam logic [6:0] BASE_RIGHT  = 7'h4D;
    localparam logic [6:0] BASE_LEFT   = 7'h4B;
    localparam logic [6:0] BASE_HOME   = 7'h47;
    localparam logic [6:0] BASE_END    = 7'h4F;
    localparam logic [6:0] BASE_INSERT = 7'h52;
    localparam logic [6:0] BASE_DELETE = 7'h53;
    localparam logic [6:0] BASE_PGUP   = 7'h49;
    localparam logic [6:0] BASE_PGDN   = 7'h51;

    localparam logic [7:0] CHR_ESC   = 8'h1B;
    localparam logic [7:0] CHR_BRKT  = 8'h5B;
    localparam logic [7:0] CHR_TILDE = 8'h7E;

    localparam logic [1:0] SEQ_IDX_SHORT_LAST = 2'd2;
    localparam logic [1:0] SEQ_IDX_LONG_LAST  = 2'd3;

    localparam logic [7:0] ROM_PLAIN [58] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A,
        8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A,
        8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] ROM_SHIFT [58] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A,
        8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A,
        8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
        8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    // One queued output job: a single character or an escape sequence.
    typedef struct packed {
        logic       is_seq;    // escape sequence ESC [ data (~)
        logic       long_seq;  // four-byte form with trailing tilde
        logic [7:0] data;      // character, or third sequence byte
    } cmd_t;

    // Queue status seen by the input handshake and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/ps2tb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2tb_front
// Accepts scan codes, tracks modifier state and builds output jobs.
// ----------------------------------------------------------------------------
module ps2tb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        code,
    input  logic              can_out,
    output logic              push,
    output ps2tb_pkg::cmd_t   push_cmd
);
    import ps2tb_pkg::*;

    logic prefix_reg, prefix_next;
    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic caps_reg,   caps_next;
    logic ctrl_reg,   ctrl_next;
    logic alt_reg,    alt_next;

    logic       release_bit;
    logic [6:0] base;
    logic [7:0] ch;
    logic [7:0] ch_caps;
    logic       is_lower;
    logic       is_upper;
    logic       gen;

    assign release_bit = code[7];
    assign base        = code[6:0];

    // Table lookup and case handling for ordinary keys.
    always_comb begin
        ch = (lshift_reg || rshift_reg) ? ROM_SHIFT[code[5:0]] : ROM_PLAIN[code[5:0]];
        ch_caps = ch;
        if (caps_reg && (((ch >= 8'h61) && (ch <= 8'h7A)) ||
                         ((ch >= 8'h41) && (ch <= 8'h5A)))) begin
            ch_caps = ch ^ 8'h20;
        end
        is_lower = (ch_caps >= 8'h61) && (ch_caps <= 8'h7A);
        is_upper = (ch_caps >= 8'h41) && (ch_caps <= 8'h5A);
    end

    always_comb begin
        prefix_next = prefix_reg;
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        caps_next   = caps_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        gen         = 1'b0;
        push_cmd    = '0;

        if (code == CODE_PREFIX) begin
            prefix_next = 1'b1;
        end else if (prefix_reg) begin
            prefix_next = 1'b0;
            if (base == BASE_CTRL) begin
                ctrl_next = !release_bit;
            end else if (base == BASE_ALT) begin
                alt_next = !release_bit;
            end else if (!release_bit && can_out) begin
                push_cmd.is_seq = 1'b1;
                gen = 1'b1;
                case (base)
                    BASE_UP:     push_cmd.data = 8'h41;
                    BASE_DOWN:   push_cmd.data = 8'h42;
                    BASE_RIGHT:  push_cmd.data = 8'h43;
                    BASE_LEFT:   push_cmd.data = 8'h44;
                    BASE_HOME:   push_cmd.data = 8'h48;
                    BASE_END:    push_cmd.data = 8'h46;
                    BASE_INSERT: begin
                        push_cmd.data = 8'h32;
                        push_cmd.long_seq = 1'b1;
                    end
                    BASE_DELETE: begin
                        push_cmd.data = 8'h33;
                        push_cmd.long_seq = 1'b1;
                    end
                    BASE_PGUP: begin
                        push_cmd.data = 8'h35;
                        push_cmd.long_seq = 1'b1;
                    end
                    BASE_PGDN: begin
                        push_cmd.data = 8'h36;
                        push_cmd.long_seq = 1'b1;
                    end
                    default: gen = 1'b0;
                endcase
            end
        end else if (code == CODE_LSHIFT_DN) begin
            lshift_next = 1'b1;
        end else if (code == CODE_RSHIFT_DN) begin
            rshift_next = 1'b1;
        end else if (code == CODE_LSHIFT_UP) begin
            lshift_next = 1'b0;
        end else if (code == CODE_RSHIFT_UP) begin
            rshift_next = 1'b0;
        end else if (code == CODE_CAPS) begin
            caps_next = !caps_reg;
        end else if (base == BASE_CTRL) begin
            ctrl_next = !release_bit;
        end else if (base == BASE_ALT) begin
            alt_next = !release_bit;
        end else if ((code < ROM_SIZE) && (ch_caps != 8'h00) && can_out) begin
            gen = 1'b1;
            push_cmd.data = ch_caps;
            if (ctrl_reg && (is_lower || is_upper)) begin
                push_cmd.data = {3'b000, ch_caps[4:0]};
            end
        end
    end

    assign push = accept && gen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= 1'b0;
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            caps_reg   <= 1'b0;
            ctrl_reg   <= 1'b0;
            alt_reg    <= 1'b0;
        end else if (accept) begin
            prefix_reg <= prefix_next;
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            caps_reg   <= caps_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
        end
    end

endmodule

// ===== rtl/ps2tb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2tb_queue
// Short job queue between the decoder front end and the byte sequencer.
// ----------------------------------------------------------------------------
module ps2tb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ps2tb_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output ps2tb_pkg::cmd_t   head_cmd,
    output ps2tb_pkg::qstat_t stat
);
    import ps2tb_pkg::*;

    cmd_t                q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_cmd   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/ps2tb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2tb_back
// Expands queued jobs into terminal bytes behind a registered output.
// ----------------------------------------------------------------------------
module ps2tb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ps2tb_pkg::cmd_t   head_cmd,
    input  ps2tb_pkg::qstat_t stat,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import ps2tb_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg,  data_next;
    logic       last_reg,  last_next;
    logic [1:0] idx_reg,   idx_next;

    logic       load;
    logic [1:0] last_idx;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign load = !stat.empty && (!valid_reg || m_tready);

    always_comb begin
        if (!head_cmd.is_seq) begin
            last_idx = '0;
        end else if (head_cmd.long_seq) begin
            last_idx = SEQ_IDX_LONG_LAST;
        end else begin
            last_idx = SEQ_IDX_SHORT_LAST;
        end
        cur_last = (idx_reg == last_idx);

        if (!head_cmd.is_seq) begin
            cur_byte = head_cmd.data;
        end else begin
            case (idx_reg)
                2'd0:    cur_byte = CHR_ESC;
                2'd1:    cur_byte = CHR_BRKT;
                2'd2:    cur_byte = head_cmd.data;
                default: cur_byte = CHR_TILDE;
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            data_next  = cur_byte;
            last_next  = cur_last;
            if (cur_last) begin
                pop      = 1'b1;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/ps2_scancode_to_terminal_bytes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_to_terminal_bytes
// Scan-code set 1 keyboard bytes in, terminal characters and escapes out.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one raw keyboard byte. The decoder tracks
// the E0 prefix, both shift keys, caps lock, ctrl and alt, and produces zero,
// one, three or four terminal bytes per item on the master stream; m_tlast
// marks the final byte that an item causes. Ordinary presses become one
// character (ctrl maps letters to 1..26), and ten extended navigation keys
// become ANSI escape sequences such as ESC [ A or ESC [ 3 ~. The front end
// classifies an item combinationally and takes a new item every cycle as
// long as its two-entry job queue has room; modifier-only items never enter
// the queue. The back end sends one byte per cycle from a registered output
// while a job waits and the sink is ready, so a character job yields one byte
// and an escape sequence three or four; the sequencer sets the sustained rate.
// Output is produced only when terminal_attached is set and input_grabbed is
// clear; the key state is tracked either way. Register 0 (terminal_attached)
// lies at byte address 0 and register 1 (input_grabbed) at address 4, both in
// bit 0. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module ps2_scancode_to_terminal_bytes (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_code
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last_byte
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ps2tb_pkg::*;

    localparam logic REG_TERMINAL = 1'b0;
    localparam logic REG_GRABBED  = 1'b1;

    logic   term_reg;
    logic   grab_reg;
    logic   cfg_wr;
    logic   can_out;
    logic   accept;
    logic   push;
    logic   pop;
    cmd_t   push_cmd;
    cmd_t   head_cmd;
    qstat_t stat;

    // The register index is paddr[2]; the low address bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= 1'b0;
            grab_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TERMINAL: term_reg <= pwdata[0];
                REG_GRABBED:  grab_reg <= pwdata[0];
                default:      term_reg <= term_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TERMINAL: prdata = {31'b0, term_reg};
            REG_GRABBED:  prdata = {31'b0, grab_reg};
            default:      prdata = '0;
        endcase
    end

    assign can_out  = term_reg && !grab_reg;
    assign s_tready = !stat.full;
    assign accept   = s_tvalid && s_tready;

    ps2tb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .code     (s_tdata),
        .can_out  (can_out),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ps2tb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (stat)
    );

    ps2tb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
